@@ hw/rtl/dtc_pkg.sv @@
package dtc_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_ROWS_DEF   = 1024;
    localparam int MAX_COLS_DEF   = 1024;
    localparam int VALUE_BITS_DEF = 32;

    // Fixed field widths
    localparam int POS_BITS   = 21;
    localparam int COL_BITS   = 10;
    localparam int ROW_BITS   = 10;
    localparam int CNT_BITS   = 11;
    localparam int DIMREG_BITS = 11;
    localparam int EPS_BITS   = 31;
    // Dimension compares are done at this width so that any MAX_* fits
    localparam int DIM_BITS   = 17;

    // Configuration port
    localparam int CFG_IDX_BITS  = 4;
    localparam int CFG_DATA_BITS = 31;

    localparam logic [CFG_IDX_BITS-1:0] CFG_NUM_ROWS       = 4'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NUM_COLUMNS    = 4'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_EPS            = 4'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DIAGONAL_FIRST = 4'd3;

    localparam logic [DIMREG_BITS-1:0] NUM_ROWS_RST    = 11'd1024;
    localparam logic [DIMREG_BITS-1:0] NUM_COLUMNS_RST = 11'd1024;

    // Result kinds
    localparam logic KIND_ENTRY   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Result queue depth, power of two, at least 4
    localparam int QUEUE_DEPTH = 4;

    typedef logic [DIM_BITS-1:0] t_dim;

endpackage

@@ hw/rtl/dtc_if.sv @@
interface dtc_in_if #(
    parameter int VALUE_BITS = dtc_pkg::VALUE_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface dtc_out_if #(
    parameter int VALUE_BITS = dtc_pkg::VALUE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [dtc_pkg::POS_BITS-1:0]  position;
    logic [dtc_pkg::COL_BITS-1:0]  column;
    logic [VALUE_BITS-1:0]         entry_value;
    logic [dtc_pkg::ROW_BITS-1:0]  row_index;
    logic [dtc_pkg::CNT_BITS-1:0]  row_entries;
    logic                          last;

    modport source (output valid, output kind, output position, output column,
                    output entry_value, output row_index, output row_entries,
                    output last, input ready);
    modport sink   (input valid, input kind, input position, input column,
                    input entry_value, input row_index, input row_entries,
                    input last, output ready);
endinterface

interface dtc_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [dtc_pkg::CFG_IDX_BITS-1:0]  index;
    logic [dtc_pkg::CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/dtc_result_queue.sv @@
module dtc_result_queue #(
    parameter int WORD_BITS = 8,
    parameter int DEPTH     = dtc_pkg::QUEUE_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [1:0]                   i_push_cnt,
    input  logic [WORD_BITS-1:0]         i_word0,
    input  logic [WORD_BITS-1:0]         i_word1,
    input  logic                         i_pop,
    output logic                         o_valid,
    output logic [WORD_BITS-1:0]         o_word,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int PtrBits = $clog2(DEPTH);
    localparam int CntBits = $clog2(DEPTH + 1);

    logic [WORD_BITS-1:0] r_mem [DEPTH];
    logic [PtrBits-1:0]   r_head, n_head;
    logic [PtrBits-1:0]   r_tail, n_tail;
    logic [CntBits-1:0]   r_count, n_count;
    logic                 pop_ok;

    assign pop_ok  = i_pop && (r_count != '0);
    assign n_head  = pop_ok ? PtrBits'(r_head + 1'b1) : r_head;
    assign n_tail  = PtrBits'(r_tail + PtrBits'(i_push_cnt));
    assign n_count = CntBits'(r_count + CntBits'(i_push_cnt) - CntBits'(pop_ok));

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_tail] <= i_word0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[PtrBits'(r_tail + 1'b1)] <= i_word1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_word  = r_mem[r_head];
    assign o_count = r_count;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_cnt != 2'd0) |-> ({1'b0, r_count} + (CntBits+1)'(i_push_cnt)
                                  <= (CntBits+1)'(DEPTH)))
        else $error("result queue overflow");

    a_count_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_cnt == 2'd0 && pop_ok) |=> r_count == $past(r_count) - 1'b1)
        else $error("result queue count out of step");

    a_tail_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        PtrBits'(r_head + PtrBits'(r_count)) == r_tail)
        else $error("result queue pointers disagree with count");
`endif

endmodule

@@ hw/rtl/dense_to_csr_converter.sv @@
// An accepted element is held in the input register, then turned into its results
// and written into the result queue, whose head word drives o_csr.
// One element per cycle is taken while the queue has room for two results;
// the output port moves one word per cycle while o_csr.ready is high, so a row
// end that also keeps an entry puts two words on the output.
// Reset (synchronous, active low): counters, registers to defaults, queue empty.
module dense_to_csr_converter #(
    parameter int MAX_ROWS   = dtc_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS   = dtc_pkg::MAX_COLS_DEF,
    parameter int VALUE_BITS = dtc_pkg::VALUE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dtc_cfg_if.sink     i_cfg,
    dtc_in_if.sink      i_elem,
    dtc_out_if.source   o_csr
);

    localparam int CmpBits  = (VALUE_BITS > dtc_pkg::EPS_BITS) ? VALUE_BITS
                                                              : dtc_pkg::EPS_BITS;
    localparam int Depth    = dtc_pkg::QUEUE_DEPTH;
    localparam int QCntBits = $clog2(Depth + 1);
    localparam dtc_pkg::t_dim MaxRows = dtc_pkg::DIM_BITS'(MAX_ROWS);
    localparam dtc_pkg::t_dim MaxCols = dtc_pkg::DIM_BITS'(MAX_COLS);

    typedef struct packed {
        logic                              kind;
        logic [dtc_pkg::POS_BITS-1:0]      position;
        logic [dtc_pkg::COL_BITS-1:0]      column;
        logic [VALUE_BITS-1:0]             entry_value;
        logic [dtc_pkg::ROW_BITS-1:0]      row_index;
        logic [dtc_pkg::CNT_BITS-1:0]      row_entries;
        logic                              last;
    } t_result;

    localparam int WordBits = $bits(t_result);

    // Configuration registers
    logic [dtc_pkg::DIMREG_BITS-1:0] r_num_rows;
    logic [dtc_pkg::DIMREG_BITS-1:0] r_num_cols;
    logic [dtc_pkg::EPS_BITS-1:0]    r_eps;
    logic                            r_diag_first;

    // Input register
    logic                  r_in_valid;
    logic [VALUE_BITS-1:0] r_in_value;

    // Row state
    logic [dtc_pkg::COL_BITS-1:0] r_col_count, n_col_count;
    logic [dtc_pkg::ROW_BITS-1:0] r_row_count, n_row_count;
    logic [dtc_pkg::POS_BITS-1:0] r_row_start, n_row_start;
    logic [dtc_pkg::CNT_BITS-1:0] r_row_fill,  n_row_fill;

    logic                         consume;
    logic [QCntBits-1:0]          q_count;
    logic                         q_valid;
    logic [WordBits-1:0]          q_word;
    logic [1:0]                   push_cnt;
    t_result                      entry_w, summary_w, word0, word1, head;

    dtc_pkg::t_dim                ncols, nrows;
    logic [VALUE_BITS-1:0]        mag;
    logic                         reserve, is_diag, keep, row_end, skip_slot;
    logic [dtc_pkg::CNT_BITS-1:0] fill_new;
    logic [dtc_pkg::POS_BITS-1:0] entry_pos, end_pos;

    // Configuration write
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows   <= dtc_pkg::NUM_ROWS_RST;
            r_num_cols   <= dtc_pkg::NUM_COLUMNS_RST;
            r_eps        <= '0;
            r_diag_first <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                dtc_pkg::CFG_NUM_ROWS:       r_num_rows   <= i_cfg.data[dtc_pkg::DIMREG_BITS-1:0];
                dtc_pkg::CFG_NUM_COLUMNS:    r_num_cols   <= i_cfg.data[dtc_pkg::DIMREG_BITS-1:0];
                dtc_pkg::CFG_EPS:            r_eps        <= i_cfg.data[dtc_pkg::EPS_BITS-1:0];
                dtc_pkg::CFG_DIAGONAL_FIRST: r_diag_first <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // Zero acts as one, larger values saturate to the maximum
    always_comb begin
        ncols = dtc_pkg::DIM_BITS'(r_num_cols);
        if (r_num_cols == '0) begin
            ncols = dtc_pkg::DIM_BITS'(1);
        end else if (ncols > MaxCols) begin
            ncols = MaxCols;
        end
        nrows = dtc_pkg::DIM_BITS'(r_num_rows);
        if (r_num_rows == '0) begin
            nrows = dtc_pkg::DIM_BITS'(1);
        end else if (nrows > MaxRows) begin
            nrows = MaxRows;
        end
    end

    // Input stage: hold the word until the queue has room for two results
    assign consume      = r_in_valid && (q_count <= QCntBits'(Depth - 2));
    assign i_elem.ready = !r_in_valid || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_elem.ready) begin
            r_in_valid <= i_elem.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_elem.ready && i_elem.valid) begin
            r_in_value <= i_elem.value;
        end
    end

    // Element decode; the most negative value keeps its exact magnitude
    assign mag       = r_in_value[VALUE_BITS-1] ? VALUE_BITS'(~r_in_value + 1'b1)
                                                : r_in_value;
    assign reserve   = r_diag_first && (dtc_pkg::DIM_BITS'(r_row_count) < ncols);
    assign is_diag   = reserve && (r_col_count == r_row_count);
    assign keep      = is_diag || (CmpBits'(mag) > CmpBits'(r_eps));
    assign skip_slot = reserve && (r_col_count < r_row_count);
    assign row_end   = (dtc_pkg::DIM_BITS'(r_col_count) + 1'b1) >= ncols;
    assign fill_new  = keep ? dtc_pkg::CNT_BITS'(r_row_fill + 1'b1) : r_row_fill;
    assign entry_pos = is_diag ? r_row_start
                     : dtc_pkg::POS_BITS'(r_row_start + dtc_pkg::POS_BITS'(r_row_fill)
                                          + dtc_pkg::POS_BITS'(skip_slot));
    assign end_pos   = dtc_pkg::POS_BITS'(r_row_start + dtc_pkg::POS_BITS'(fill_new));

    always_comb begin
        entry_w.kind        = dtc_pkg::KIND_ENTRY;
        entry_w.position    = entry_pos;
        entry_w.column      = r_col_count;
        entry_w.entry_value = r_in_value;
        entry_w.row_index   = r_row_count;
        entry_w.row_entries = '0;
        entry_w.last        = !row_end;

        summary_w.kind        = dtc_pkg::KIND_SUMMARY;
        summary_w.position    = end_pos;
        summary_w.column      = '0;
        summary_w.entry_value = '0;
        summary_w.row_index   = r_row_count;
        summary_w.row_entries = fill_new;
        summary_w.last        = 1'b1;

        word0 = keep ? entry_w : summary_w;
        word1 = summary_w;
    end

    assign push_cnt = consume ? (2'(keep) + 2'(row_end)) : 2'd0;

    // Counter update
    always_comb begin
        n_col_count = r_col_count;
        n_row_count = r_row_count;
        n_row_start = r_row_start;
        n_row_fill  = fill_new;
        if (row_end) begin
            n_col_count = '0;
            n_row_fill  = '0;
            if ((dtc_pkg::DIM_BITS'(r_row_count) + 1'b1) >= nrows) begin
                n_row_count = '0;
                n_row_start = '0;
            end else begin
                n_row_count = dtc_pkg::ROW_BITS'(r_row_count + 1'b1);
                n_row_start = end_pos;
            end
        end else begin
            n_col_count = dtc_pkg::COL_BITS'(r_col_count + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_count <= '0;
            r_row_count <= '0;
            r_row_start <= '0;
            r_row_fill  <= '0;
        end else if (consume) begin
            r_col_count <= n_col_count;
            r_row_count <= n_row_count;
            r_row_start <= n_row_start;
            r_row_fill  <= n_row_fill;
        end
    end

    dtc_result_queue #(
        .WORD_BITS (WordBits),
        .DEPTH     (Depth)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_word0    (word0),
        .i_word1    (word1),
        .i_pop      (o_csr.ready),
        .o_valid    (q_valid),
        .o_word     (q_word),
        .o_count    (q_count)
    );

    assign head              = t_result'(q_word);
    assign o_csr.valid       = q_valid;
    assign o_csr.kind        = head.kind;
    assign o_csr.position    = head.position;
    assign o_csr.column      = head.column;
    assign o_csr.entry_value = head.entry_value;
    assign o_csr.row_index   = head.row_index;
    assign o_csr.row_entries = head.row_entries;
    assign o_csr.last        = head.last;

`ifndef SYNTHESIS
    a_row_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && row_end) |=> (r_col_count == '0 && r_row_fill == '0))
        else $error("row end did not clear column and fill counters");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row_fill <= dtc_pkg::CNT_BITS'(r_col_count))
        else $error("row fill exceeds columns seen");

    a_hold_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !consume) |=> (r_in_valid && $stable(r_in_value)))
        else $error("held input word lost or changed");

    a_two_needs_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_cnt == 2'd2) |-> (keep && row_end))
        else $error("two results pushed without entry and row end");
`endif

endmodule

@@ tb/tb.sv @@
module tb;
    import dtc_pkg::*;

    localparam int VB           = VALUE_BITS_DEF;
    localparam int MW           = VB + 1;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 152;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT  = 4000;
    localparam int PLAN_ROWS    = 30;

    typedef struct packed {
        logic                kind;
        logic [POS_BITS-1:0] position;
        logic [COL_BITS-1:0] column;
        logic [VB-1:0]       entry_value;
        logic [ROW_BITS-1:0] row_index;
        logic [CNT_BITS-1:0] row_entries;
        logic                last;
    } csr_word_t;

    typedef enum logic [0:0] {PLAN_ELEM, PLAN_CFG} plan_op_e;
    typedef enum logic [1:0] {CHK_PREDICT, CHK_NONE, CHK_TYPED} plan_chk_e;

    typedef struct packed {
        plan_op_e               op;
        logic [VB-1:0]          value;
        logic [DIMREG_BITS-1:0] rows;
        logic [DIMREG_BITS-1:0] cols;
        logic [EPS_BITS-1:0]    eps;
        logic                   diag;
        plan_chk_e              chk;
        csr_word_t              want;
    } plan_row_t;

    localparam csr_word_t NO_WORD = '0;

    logic i_clk = 1'b0;
    logic i_rst_n;

    always #5 i_clk = ~i_clk;

    dtc_cfg_if cfg_if ();
    dtc_in_if  elem_if ();
    dtc_out_if csr_if ();

    dense_to_csr_converter u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_elem  (elem_if),
        .o_csr   (csr_if)
    );

    // Predicted register file and stream position
    logic [DIMREG_BITS-1:0] cfg_rows = NUM_ROWS_RST;
    logic [DIMREG_BITS-1:0] cfg_cols = NUM_COLUMNS_RST;
    logic [EPS_BITS-1:0]    cfg_eps  = '0;
    logic                   cfg_diag = 1'b0;
    logic [COL_BITS-1:0]    col_cnt  = '0;
    logic [ROW_BITS-1:0]    row_cnt  = '0;
    logic [POS_BITS-1:0]    row_base = '0;
    logic [CNT_BITS-1:0]    row_fill = '0;

    csr_word_t   step_words [2];
    csr_word_t   pending_words [$];
    int unsigned mismatches = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned quiet_cycles = 0;

    plan_row_t directed_plan [PLAN_ROWS];

    function automatic int unsigned dim_of(input logic [DIMREG_BITS-1:0] r, input int unsigned cap);
        if (r == 0) return 1;
        if (r > cap) return cap;
        return r;
    endfunction

    // Advance the predicted stream by one element, leave its words in step_words
    function automatic int convert_elem(input logic [VB-1:0] v);
        logic [MW-1:0]       mag;
        int unsigned         ncols;
        int unsigned         nrows;
        logic                reserve;
        logic                on_diag;
        logic [POS_BITS-1:0] pos;
        logic [POS_BITS-1:0] row_end;
        int                  n;
        mag     = v[VB-1] ? MW'(0) - {1'b1, v} : {1'b0, v};
        ncols   = dim_of(cfg_cols, MAX_COLS_DEF);
        nrows   = dim_of(cfg_rows, MAX_ROWS_DEF);
        reserve = cfg_diag && (row_cnt < ncols);
        on_diag = reserve && (col_cnt == row_cnt);
        n = 0;
        if (on_diag || mag > MW'(cfg_eps)) begin
            // off-diagonal entries left of the diagonal skip the reserved slot
            pos = on_diag ? row_base
                          : row_base + POS_BITS'(row_fill)
                            + POS_BITS'(reserve && col_cnt < row_cnt);
            step_words[n] = '{KIND_ENTRY, pos, col_cnt, v, row_cnt, CNT_BITS'(0), 1'b0};
            n++;
            row_fill = row_fill + 1'b1;
        end
        if (col_cnt + 1 >= ncols) begin
            row_end = row_base + POS_BITS'(row_fill);
            step_words[n] = '{KIND_SUMMARY, row_end, COL_BITS'(0), VB'(0), row_cnt, row_fill, 1'b0};
            n++;
            row_base = row_end;
            row_fill = '0;
            col_cnt  = '0;
            if (row_cnt + 1 >= nrows) begin
                row_cnt  = '0;
                row_base = '0;
            end else begin
                row_cnt = row_cnt + 1'b1;
            end
        end else begin
            col_cnt = col_cnt + 1'b1;
        end
        if (n > 0) step_words[n-1].last = 1'b1;
        return n;
    endfunction

    function automatic logic [DIMREG_BITS-1:0] pick_dim();
        case ($urandom_range(9))
            0: return '0;
            1: return DIMREG_BITS'(1);
            2: return DIMREG_BITS'(MAX_ROWS_DEF);
            3: return '1;
            4: return DIMREG_BITS'($urandom_range(2047));
            default: return DIMREG_BITS'($urandom_range(12, 2));
        endcase
    endfunction

    function automatic logic [VB-1:0] pick_value();
        logic [MW-1:0] m;
        logic [VB-1:0] v;
        case ($urandom_range(9))
            0: return '0;
            1: return {1'b1, {(VB-1){1'b0}}};
            2: return {1'b0, {(VB-1){1'b1}}};
            3, 4: begin
                // land right around the keep threshold
                m = MW'(cfg_eps) + MW'($urandom_range(2)) - MW'(1);
                return $urandom_range(1) ? -m[VB-1:0] : m[VB-1:0];
            end
            5: begin
                v = VB'($urandom_range(15));
                return $urandom_range(1) ? -v : v;
            end
            default: return VB'($urandom());
        endcase
    endfunction

    task automatic push_elem(input logic [VB-1:0] v, input plan_chk_e chk, input csr_word_t want);
        int n;
        while ($urandom_range(99) < send_idle_pct) begin
            elem_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        elem_if.valid <= 1'b1;
        elem_if.value <= v;
        @(posedge i_clk);
        while (!elem_if.ready) @(posedge i_clk);
        n = convert_elem(v);
        case (chk)
            CHK_PREDICT: for (int k = 0; k < n; k++) pending_words.push_back(step_words[k]);
            CHK_TYPED:   pending_words.push_back(want);
            default:     ;
        endcase
    endtask

    // Drop valid, wait for every expected word, then let the pipeline empty
    task automatic settle();
        elem_if.valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input logic [DIMREG_BITS-1:0] nr, input logic [DIMREG_BITS-1:0] nc,
                             input logic [EPS_BITS-1:0] thr, input logic dg);
        logic [CFG_IDX_BITS-1:0]  idx;
        logic [CFG_DATA_BITS-1:0] d;
        for (int k = 0; k < 5; k++) begin
            case (k)
                0: begin idx = CFG_NUM_ROWS;       d = CFG_DATA_BITS'(nr); end
                1: begin idx = CFG_NUM_COLUMNS;    d = CFG_DATA_BITS'(nc); end
                2: begin idx = CFG_EPS;            d = CFG_DATA_BITS'(thr); end
                3: begin idx = CFG_DIAGONAL_FIRST; d = CFG_DATA_BITS'(dg); end
                default: begin
                    // unmapped index, must leave every register alone
                    idx = CFG_IDX_BITS'(CFG_DIAGONAL_FIRST + 1 + $urandom_range(11));
                    d   = CFG_DATA_BITS'($urandom());
                end
            endcase
            cfg_if.valid <= 1'b1;
            cfg_if.index <= idx;
            cfg_if.data  <= d;
            @(posedge i_clk);
            while (!cfg_if.ready) @(posedge i_clk);
            case (idx)
                CFG_NUM_ROWS:       cfg_rows = d[DIMREG_BITS-1:0];
                CFG_NUM_COLUMNS:    cfg_cols = d[DIMREG_BITS-1:0];
                CFG_EPS:            cfg_eps  = d[EPS_BITS-1:0];
                CFG_DIAGONAL_FIRST: cfg_diag = d[0];
                default:            ;
            endcase
        end
        cfg_if.valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        csr_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin : check_csr
        csr_word_t got;
        csr_word_t want;
        if (i_rst_n && csr_if.valid && csr_if.ready) begin
            got = '{csr_if.kind, csr_if.position, csr_if.column, csr_if.entry_value,
                    csr_if.row_index, csr_if.row_entries, csr_if.last};
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected csr word: kind=%0d pos=%0d col=%0d value=%h row=%0d entries=%0d last=%0d",
                             got.kind, got.position, got.column, got.entry_value,
                             got.row_index, got.row_entries, got.last);
            end else begin
                want = pending_words.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("csr word mismatch at %0t", $realtime);
                        $display("  expected kind=%0d pos=%0d col=%0d value=%h row=%0d entries=%0d last=%0d",
                                 want.kind, want.position, want.column, want.entry_value,
                                 want.row_index, want.row_entries, want.last);
                        $display("  actual   kind=%0d pos=%0d col=%0d value=%h row=%0d entries=%0d last=%0d",
                                 got.kind, got.position, got.column, got.entry_value,
                                 got.row_index, got.row_entries, got.last);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((elem_if.valid && elem_if.ready) || (csr_if.valid && csr_if.ready)
            || (cfg_if.valid && cfg_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[dense_to_csr_converter] ERROR");
            $finish;
        end
    end

    initial begin
        logic [DIMREG_BITS-1:0] nr;
        logic [DIMREG_BITS-1:0] nc;
        logic [EPS_BITS-1:0]    thr;

        i_rst_n       = 1'b0;
        elem_if.valid = 1'b0;
        elem_if.value = '0;
        cfg_if.valid  = 1'b0;
        cfg_if.index  = '0;
        cfg_if.data   = '0;
        csr_if.ready  = 1'b0;

        directed_plan = '{
            // reset settings: zero dropped, extremes kept
            '{PLAN_ELEM, 32'h0000_0000, 11'd0, 11'd0, 31'd0, 1'b0, CHK_NONE, NO_WORD},
            '{PLAN_ELEM, 32'h8000_0000, 11'd0, 11'd0, 31'd0, 1'b0, CHK_TYPED,
              '{KIND_ENTRY, 21'd0, 10'd1, 32'h8000_0000, 10'd0, 11'd0, 1'b1}},
            '{PLAN_ELEM, 32'h7fff_ffff, 11'd0, 11'd0, 31'd0, 1'b0, CHK_TYPED,
              '{KIND_ENTRY, 21'd1, 10'd2, 32'h7fff_ffff, 10'd0, 11'd0, 1'b1}},
            // zero column count mid-row: row ends at once
            '{PLAN_CFG, 32'h0, 11'd1024, 11'd0, 31'd0, 1'b0, CHK_PREDICT, NO_WORD},
            '{PLAN_ELEM, 32'hffff_ffff, 11'd0, 11'd0, 31'd0, 1'b0, CHK_PREDICT, NO_WORD},
            // widest threshold: only the most negative value passes
            '{PLAN_CFG, 32'h0, 11'd0, 11'd0, 31'h7fff_ffff, 1'b0, CHK_PREDICT, NO_WORD},
            '{PLAN_ELEM, 32'h8000_0000, 11'd0, 11'd0, 31'd0, 1'b0, CHK_PREDICT, NO_WORD},
            '{PLAN_ELEM, 32'h7fff_ffff, 11'd0, 11'd0, 31'd0, 1'b0, CHK_TYPED,
              '{KIND_SUMMARY, 21'd0, 10'd0, 32'd0, 10'd0, 11'd0, 1'b1}},
            // diagonal reserve on a 3x4 matrix
            '{PLAN_CFG, 32'h0, 11'd3, 11'd4, 31'd10, 1'b1, CHK_PREDICT, NO_WORD},
            '{PLAN_ELEM, 32'h0000_0000, 11'd0, 11'd0, 31'd0, 1'b0, CHK_PREDICT, NO_WORD},
            '{PLAN_ELEM, 32'h0000_000b, 11'd0, 11'd0, 31'd0, 1'b0, CHK_PREDICT, NO_WORD},
            '{PLAN_ELEM, 32'hffff_fff6, 11'd0, 11'd0, 31'd0, 1'b0, CHK_PREDICT, NO_WORD},
            '{PLAN_ELEM, 32'h0000_0005, 11'd0, 11'd0, 31'd0, 1'b0, CHK_PREDICT, NO_WORD},
            '{PLAN_ELEM, 32'hffff_fff5, 11'd0, 11'd0, 31'd0, 1'b0, CHK_PREDICT, NO_WORD},
            '{PLAN_ELEM, 32'h0000_0000, 11'd0, 11'd0, 31'd0, 1'b0, CHK_PREDICT, NO_WORD},
            '{PLAN_ELEM, 32'h0000_000a, 11'd0, 11'd0, 31'd0, 1'b0, CHK_PREDICT, NO_WORD},
            '{PLAN_ELEM, 32'h7fff_ffff, 11'd0, 11'd0, 31'd0, 1'b0, CHK_PREDICT, NO_WORD},
            '{PLAN_ELEM, 32'h0000_0003, 11'd0, 11'd0, 31'd0, 1'b0, CHK_PREDICT, NO_WORD},
            '{PLAN_ELEM, 32'h8000_0000, 11'd0, 11'd0, 31'd0, 1'b0, CHK_PREDICT, NO_WORD},
            '{PLAN_ELEM, 32'hffff_ffff, 11'd0, 11'd0, 31'd0, 1'b0, CHK_PREDICT, NO_WORD},
            '{PLAN_ELEM, 32'h0000_0000, 11'd0, 11'd0, 31'd0, 1'b0, CHK_PREDICT, NO_WORD},
            // more rows than columns: rows past the last column have no reserve
            '{PLAN_CFG, 32'h0, 11'd4, 11'd2, 31'd0, 1'b1, CHK_PREDICT, NO_WORD},
            '{PLAN_ELEM, 32'h0000_0000, 11'd0, 11'd0, 31'd0, 1'b0, CHK_PREDICT, NO_WORD},
            '{PLAN_ELEM, 32'h0000_0000, 11'd0, 11'd0, 31'd0, 1'b0, CHK_PREDICT, NO_WORD},
            '{PLAN_ELEM, 32'h0000_0005, 11'd0, 11'd0, 31'd0, 1'b0, CHK_PREDICT, NO_WORD},
            '{PLAN_ELEM, 32'h0000_0000, 11'd0, 11'd0, 31'd0, 1'b0, CHK_PREDICT, NO_WORD},
            '{PLAN_ELEM, 32'h0000_0006, 11'd0, 11'd0, 31'd0, 1'b0, CHK_PREDICT, NO_WORD},
            '{PLAN_ELEM, 32'h0000_0000, 11'd0, 11'd0, 31'd0, 1'b0, CHK_PREDICT, NO_WORD},
            '{PLAN_ELEM, 32'hffff_fff9, 11'd0, 11'd0, 31'd0, 1'b0, CHK_PREDICT, NO_WORD},
            '{PLAN_ELEM, 32'h0000_0001, 11'd0, 11'd0, 31'd0, 1'b0, CHK_PREDICT, NO_WORD}
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 15;
        recv_idle_pct <= 78;
        foreach (directed_plan[i]) begin
            if (directed_plan[i].op == PLAN_CFG) begin
                settle();
                configure(directed_plan[i].rows, directed_plan[i].cols,
                          directed_plan[i].eps, directed_plan[i].diag);
            end else begin
                push_elem(directed_plan[i].value, directed_plan[i].chk, directed_plan[i].want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            send_idle_pct = (ph < 4) ? 15 : (ph < 8) ? 78 : 0;
            recv_idle_pct <= (ph < 4) ? 78 : (ph < 8) ? 15 : 0;
            if (ph == 0) begin
                nr = '1;
                nc = DIMREG_BITS'(2);
            end else if (ph == 1) begin
                nr = DIMREG_BITS'(1);
                nc = '1;
            end else begin
                nr = pick_dim();
                nc = pick_dim();
            end
            case ($urandom_range(3))
                0:       thr = '0;
                1:       thr = '1;
                2:       thr = EPS_BITS'($urandom());
                default: thr = EPS_BITS'($urandom_range(40));
            endcase
            settle();
            configure(nr, nc, thr, 1'($urandom_range(1)));
            repeat (PHASE_ITEMS) push_elem(pick_value(), CHK_PREDICT, NO_WORD);
        end

        settle();
        if (mismatches == 0)
            $display("[dense_to_csr_converter] OK");
        else
            $display("[dense_to_csr_converter] ERROR");
        $finish;
    end

endmodule
